### src/bsid_pkg.sv
// ----------------------------------------------------------------------------
// bsid_pkg
// Shared types and codes for the bitmap set intersection / difference core.
// ----------------------------------------------------------------------------
package bsid_pkg;

  // field widths
  localparam int VALUE_W     = 10;
  localparam int REQ_W       = 2;
  localparam int SEL_W       = 2;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 16;

  // request kinds (carried on s_tuser)
  localparam logic [REQ_W-1:0] REQ_ADD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND  = 2'd2;

  // find list selects
  localparam logic [SEL_W-1:0] LIST_BOTH   = 2'd0;
  localparam logic [SEL_W-1:0] LIST_A_ONLY = 2'd1;
  localparam logic [SEL_W-1:0] LIST_B_ONLY = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;      // write zero to both stores at scan address
    logic add_a;       // mark item value in set a
    logic add_b;       // mark item value in set b
    logic load_req;    // latch start address and list select
    logic advance;     // step scan address
    logic cap_result;  // capture the entry under test as a hit
    logic cap_miss;    // capture a not-found result
    logic load_out;    // move result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_last;     // scan address is the top entry
    logic rd_last;     // entry under test is the top entry
    logic hit;         // entry under test belongs to the selected list
    logic in_range;    // item value lies inside the store
    logic out_free;    // output register can take a result
  } status_t;

endpackage

### src/bsid_dpath.sv
// ----------------------------------------------------------------------------
// bsid_dpath
// Membership stores, scan address, read pipeline and result registers.
// ----------------------------------------------------------------------------
module bsid_dpath #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bsid_pkg::cmd_t                 cmd,
  output bsid_pkg::status_t              status,
  input  logic [bsid_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bsid_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser
);

  localparam int AW = $clog2(VALUE_RANGE);
  localparam logic [AW-1:0] LAST = AW'(VALUE_RANGE - 1);

  // one bit per value for each set
  logic mem_a [VALUE_RANGE];
  logic mem_b [VALUE_RANGE];

  logic [bsid_pkg::VALUE_W-1:0] item_value;
  logic [bsid_pkg::SEL_W-1:0]   list_in;
  logic [AW-1:0]                item_addr;
  logic [AW-1:0]                wr_addr;
  logic                         wr_bit;

  logic [AW-1:0]                scan_addr;
  logic [AW-1:0]                rd_addr;
  logic                         rd_a;
  logic                         rd_b;
  logic [bsid_pkg::SEL_W-1:0]   sel;
  logic                         res_found;
  logic [bsid_pkg::VALUE_W-1:0] res_value;

  function automatic logic list_has(input logic a, input logic b,
                                    input logic [bsid_pkg::SEL_W-1:0] s);
    logic r;
    case (s)
      bsid_pkg::LIST_BOTH:   r = a & b;
      bsid_pkg::LIST_A_ONLY: r = a & ~b;
      bsid_pkg::LIST_B_ONLY: r = ~a & b;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  // input beat fields
  assign item_value = s_tdata[bsid_pkg::VALUE_W-1:0];
  assign list_in    = s_tdata[bsid_pkg::VALUE_W+bsid_pkg::SEL_W-1:bsid_pkg::VALUE_W];
  assign item_addr  = AW'(item_value);

  // write port: clearing pass or add
  always_comb begin
    wr_addr = cmd.clr_wr ? scan_addr : item_addr;
    wr_bit  = ~cmd.clr_wr;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.add_a) begin
      mem_a[wr_addr] <= wr_bit;
    end
    if (cmd.clr_wr || cmd.add_b) begin
      mem_b[wr_addr] <= wr_bit;
    end
  end

  // registered read of the scan address
  always_ff @(posedge clk) begin
    rd_a    <= mem_a[scan_addr];
    rd_b    <= mem_b[scan_addr];
    rd_addr <= scan_addr;
  end

  // scan address, saturates at the top entry
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (cmd.load_req) begin
      scan_addr <= item_addr;
    end else if (cmd.advance && (scan_addr != LAST)) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // list select of the pending find
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      sel <= list_in;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.cap_result) begin
      res_found <= 1'b1;
      res_value <= bsid_pkg::VALUE_W'(rd_addr);
    end else if (cmd.cap_miss) begin
      res_found <= 1'b0;
      res_value <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= res_found;
      m_tdata <= {{(bsid_pkg::M_TDATA_W-bsid_pkg::VALUE_W){1'b0}}, res_value};
    end
  end

  // status back to the controller
  always_comb begin
    status.at_last  = (scan_addr == LAST);
    status.rd_last  = (rd_addr == LAST);
    status.hit      = list_has(rd_a, rd_b, sel);
    status.in_range = (32'(item_value) < 32'(VALUE_RANGE));
    status.out_free = ~m_tvalid | m_tready;
  end

endmodule

### src/bsid_ctrl.sv
// ----------------------------------------------------------------------------
// bsid_ctrl
// Sequencer for clearing, adds and find-next scans.
// ----------------------------------------------------------------------------
module bsid_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bsid_pkg::REQ_W-1:0]  s_tuser,
  input  bsid_pkg::status_t           status,
  output bsid_pkg::cmd_t              cmd
);

  bsid_pkg::state_t state;
  bsid_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsid_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsid_pkg::ST_CLEAR: begin
        if (status.at_last) begin
          state_next = bsid_pkg::ST_IDLE;
        end
      end
      bsid_pkg::ST_IDLE: begin
        if (s_tvalid && (s_tuser == bsid_pkg::REQ_FIND)) begin
          state_next = status.in_range ? bsid_pkg::ST_FILL : bsid_pkg::ST_DONE;
        end
      end
      bsid_pkg::ST_FILL: begin
        state_next = bsid_pkg::ST_SCAN;
      end
      bsid_pkg::ST_SCAN: begin
        if (status.hit || status.rd_last) begin
          state_next = bsid_pkg::ST_DONE;
        end
      end
      bsid_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = bsid_pkg::ST_IDLE;
        end
      end
      default: state_next = bsid_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      bsid_pkg::ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.advance = 1'b1;
      end
      bsid_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (s_tuser)
            bsid_pkg::REQ_ADD_A: cmd.add_a = status.in_range;
            bsid_pkg::REQ_ADD_B: cmd.add_b = status.in_range;
            bsid_pkg::REQ_FIND: begin
              cmd.load_req = 1'b1;
              cmd.cap_miss = ~status.in_range;
            end
            default: ;
          endcase
        end
      end
      bsid_pkg::ST_FILL: begin
        cmd.advance = 1'b1;
      end
      bsid_pkg::ST_SCAN: begin
        cmd.advance    = 1'b1;
        cmd.cap_result = status.hit;
        cmd.cap_miss   = ~status.hit & status.rd_last;
      end
      bsid_pkg::ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

### src/bitmap_set_intersect_diff_core.sv
// ----------------------------------------------------------------------------
// bitmap_set_intersect_diff_core
// Two-set membership bitmap with ascending find-next over a only, b only or both.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass over all VALUE_RANGE entries, one
// entry per cycle, with s_tready low. An add beat is taken in the idle state.
// A find-next beat scans upward from its start value until it reaches a member
// of the selected list or the top entry; the scan reads one entry per cycle
// through the single registered read port of the stores. A find with a start
// outside the store goes straight to a not-found result. A result that is not
// taken holds the core once a following find completes.
module bitmap_set_intersect_diff_core #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // input beat
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bsid_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] item_value, [11:10] list_sel
  input  logic [bsid_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
  // result beat
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bsid_pkg::M_TDATA_W-1:0] m_tdata,   // [9:0] found_value
  output logic                           m_tuser    // [0] found
);

  bsid_pkg::cmd_t    cmd;
  bsid_pkg::status_t status;

  bsid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  bsid_dpath #(
    .VALUE_RANGE (VALUE_RANGE)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### src/bsid_props.sv
// ----------------------------------------------------------------------------
// bsid_props
// Port-level properties of the bitmap set core, bound to the top level.
// ----------------------------------------------------------------------------
module bsid_props (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bsid_pkg::REQ_W-1:0]     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bsid_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser
);

  // reset empties the output register
  a_rst_out_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // clearing pass keeps the input closed after reset
  a_rst_no_accept: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // a find closes the input while it runs
  a_find_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == bsid_pkg::REQ_FIND)) |=> !s_tready)
    else $error("input ready right after a find beat");

  // a not-found result carries a zero value and no bits above the value field
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("not-found result with nonzero value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

endmodule

bind bitmap_set_intersect_diff_core bsid_props u_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-set membership bitmap with find-next.
// A short table of directed beats walks empty-store lookups, edge values,
// repeated marks and the unused request and list codes. Random traffic
// follows: bursts of marks into set a or b, and ascending walks of one list
// that resume just above the last hit. Every find is predicted from a local copy
// of the store or from its table row, and checked field by field against the
// result stream, under several mixes of source gaps and sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_RANGE   = 1024;
  localparam int ITEMS_PER_MIX = 256;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = VALUE_RANGE + 16;
  localparam int MAX_PRINTED   = 20;

  // field widths of the core
  localparam int REQ_W     = bsid_pkg::REQ_W;
  localparam int VALUE_W   = bsid_pkg::VALUE_W;
  localparam int SEL_W     = bsid_pkg::SEL_W;
  localparam int S_TDATA_W = bsid_pkg::S_TDATA_W;
  localparam int M_TDATA_W = bsid_pkg::M_TDATA_W;

  // codes the package leaves unnamed
  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam logic [SEL_W-1:0] LIST_UNUSED = 2'd3;

  // membership bits of one value
  localparam logic [1:0] IN_A = 2'b01;
  localparam logic [1:0] IN_B = 2'b10;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
  } find_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [VALUE_W-1:0] val;
    logic [SEL_W-1:0]   sel;
    logic               typed;   // expected result written in the row
    logic               hit;
    logic [VALUE_W-1:0] at;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;    // [9:0] item_value, [11:10] list_sel
  logic [REQ_W-1:0]     s_tuser;    // [1:0] req_type
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;    // [9:0] found_value
  logic                 m_tuser;    // [0] found

  // local copy of the store and the results still owed by the core
  logic [1:0]   member_bits [VALUE_RANGE];
  find_result_t pending_finds [$];
  find_result_t got_want;

  directed_row_t directed_rows [25];

  int  send_idle_pct;
  int  sink_stall_pct;
  int  hold_left;
  int  quiet_cycles;
  int  mismatches;
  int  mix_items;
  int  n_adds;
  int  n_finds;
  int  n_found;
  int  n_missed;
  int  n_ignored;
  bit  last_found;
  logic [VALUE_W-1:0] last_value;

  bitmap_set_intersect_diff_core #(
    .VALUE_RANGE(VALUE_RANGE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // does one entry belong to the chosen list
  function automatic bit on_list(input logic [1:0] bits, input logic [SEL_W-1:0] sel);
    case (sel)
      bsid_pkg::LIST_BOTH:   return bits == (IN_A | IN_B);
      bsid_pkg::LIST_A_ONLY: return bits == IN_A;
      bsid_pkg::LIST_B_ONLY: return bits == IN_B;
      default:               return 1'b0;
    endcase
  endfunction

  // smallest member of the list at or above start
  function automatic find_result_t next_member(input logic [VALUE_W-1:0] start,
                                               input logic [SEL_W-1:0] sel);
    find_result_t r;
    r = '0;
    for (int v = int'(start); v < VALUE_RANGE; v++) begin
      if (on_list(member_bits[v], sel)) begin
        r.found = 1'b1;
        r.value = v[VALUE_W-1:0];
        break;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // offer one beat, wait for it to be taken, then update the local store
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                           input logic [SEL_W-1:0] sel, input bit typed,
                           input bit typed_hit, input logic [VALUE_W-1:0] typed_at);
    find_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {{(S_TDATA_W-SEL_W-VALUE_W){1'b0}}, sel, val};
    do @(posedge clk); while (!s_tready);
    if (req != REQ_UNUSED) begin
      mix_items++;
    end
    case (req)
      bsid_pkg::REQ_ADD_A: begin
        member_bits[val] |= IN_A;
        n_adds++;
      end
      bsid_pkg::REQ_ADD_B: begin
        member_bits[val] |= IN_B;
        n_adds++;
      end
      bsid_pkg::REQ_FIND: begin
        want = next_member(val, sel);
        if (typed) begin
          want.found = typed_hit;
          want.value = typed_at;
        end
        pending_finds.push_back(want);
        last_found = want.found;
        last_value = want.value;
        n_finds++;
        if (want.found) n_found++;
        else n_missed++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  // sink: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_finds.size() == 0) begin
        report_mismatch($sformatf("result found=%0b value=%0d with no find pending",
                                  m_tuser, m_tdata));
      end else begin
        got_want = pending_finds.pop_front();
        if (m_tuser !== got_want.found) begin
          report_mismatch($sformatf("found %0b, expected %0b", m_tuser, got_want.found));
        end
        if (m_tdata !== M_TDATA_W'(got_want.value)) begin
          report_mismatch($sformatf("found_value %0d, expected %0d",
                                    m_tdata, got_want.value));
        end
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d finds pending",
               quiet_cycles, pending_finds.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int send_mix [4];
    int sink_mix [4];
    int pick;
    int burst;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] start;
    logic [SEL_W-1:0]   sel;
    logic [REQ_W-1:0]   req;

    send_mix = '{0, 62, 0, 27};
    sink_mix = '{0, 0, 62, 27};

    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    mismatches     = 0;
    mix_items      = 0;
    n_adds         = 0;
    n_finds        = 0;
    n_found        = 0;
    n_missed       = 0;
    n_ignored      = 0;
    last_found     = 1'b0;
    last_value     = '0;
    foreach (member_bits[i]) member_bits[i] = 2'b00;

    // directed beats; the store ends up with 0 and 341 in a, 5 and 682 in b, 700 and 1023 in both
    directed_rows = '{
      '{bsid_pkg::REQ_FIND,  10'd0,    bsid_pkg::LIST_BOTH,   1'b1, 1'b0, 10'd0},  // empty store
      '{bsid_pkg::REQ_FIND,  10'd0,    bsid_pkg::LIST_A_ONLY, 1'b1, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd1023, bsid_pkg::LIST_B_ONLY, 1'b1, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_A, 10'd0,    bsid_pkg::LIST_BOTH,   1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_A, 10'd1023, LIST_UNUSED,           1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_B, 10'd1023, bsid_pkg::LIST_B_ONLY, 1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_B, 10'd5,    bsid_pkg::LIST_A_ONLY, 1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_A, 10'd700,  bsid_pkg::LIST_BOTH,   1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_A, 10'd700,  bsid_pkg::LIST_BOTH,   1'b0, 1'b0, 10'd0},  // mark twice
      '{bsid_pkg::REQ_ADD_B, 10'd700,  bsid_pkg::LIST_BOTH,   1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd0,    bsid_pkg::LIST_BOTH,   1'b1, 1'b1, 10'd700},
      '{bsid_pkg::REQ_FIND,  10'd701,  bsid_pkg::LIST_BOTH,   1'b1, 1'b1, 10'd1023},
      '{bsid_pkg::REQ_FIND,  10'd0,    bsid_pkg::LIST_A_ONLY, 1'b1, 1'b1, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd1,    bsid_pkg::LIST_A_ONLY, 1'b1, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd0,    bsid_pkg::LIST_B_ONLY, 1'b1, 1'b1, 10'd5},
      '{bsid_pkg::REQ_FIND,  10'd6,    bsid_pkg::LIST_B_ONLY, 1'b1, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd0,    LIST_UNUSED,           1'b1, 1'b0, 10'd0},  // empty list
      '{REQ_UNUSED,          10'd6,    bsid_pkg::LIST_B_ONLY, 1'b0, 1'b0, 10'd0},  // dropped
      '{bsid_pkg::REQ_FIND,  10'd6,    bsid_pkg::LIST_B_ONLY, 1'b1, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd1023, bsid_pkg::LIST_BOTH,   1'b1, 1'b1, 10'd1023},
      '{bsid_pkg::REQ_ADD_B, 10'd682,  bsid_pkg::LIST_A_ONLY, 1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_ADD_A, 10'd341,  bsid_pkg::LIST_B_ONLY, 1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd6,    bsid_pkg::LIST_B_ONLY, 1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd1,    bsid_pkg::LIST_A_ONLY, 1'b0, 1'b0, 10'd0},
      '{bsid_pkg::REQ_FIND,  10'd1023, LIST_UNUSED,           1'b1, 1'b0, 10'd0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].req, directed_rows[i].val, directed_rows[i].sel,
                directed_rows[i].typed, directed_rows[i].hit, directed_rows[i].at);
    end

    // random traffic under each mix of source gaps and sink stalls
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = send_mix[m];
      sink_stall_pct = sink_mix[m];
      mix_items      = 0;

      // long sink hold-off while finds keep coming, so the core backs up
      if (m == 2) begin
        hold_left <= HOLD_CYCLES;
        for (int k = 0; k < 8; k++) begin
          send_beat(bsid_pkg::REQ_FIND,
                    VALUE_W'($urandom_range(VALUE_RANGE - 1, VALUE_RANGE - 40)),
                    SEL_W'($urandom_range(3)), 1'b0, 1'b0, '0);
        end
      end

      while (mix_items < ITEMS_PER_MIX) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          // burst of marks, half of them clustered
          burst = $urandom_range(6, 1);
          base  = VALUE_W'($urandom_range(VALUE_RANGE - 1));
          for (int k = 0; k < burst; k++) begin
            req = $urandom_range(1) ? bsid_pkg::REQ_ADD_B : bsid_pkg::REQ_ADD_A;
            if ($urandom_range(1)) start = base + VALUE_W'($urandom_range(15));
            else start = VALUE_W'($urandom_range(VALUE_RANGE - 1));
            send_beat(req, start, SEL_W'($urandom_range(3)), 1'b0, 1'b0, '0);
          end
        end else if (pick < 80) begin
          // ascending walk of one list
          sel   = SEL_W'($urandom_range(2));
          start = ($urandom_range(3) == 0) ? '0 : VALUE_W'($urandom_range(VALUE_RANGE - 1));
          burst = $urandom_range(8, 2);
          for (int k = 0; k < burst; k++) begin
            send_beat(bsid_pkg::REQ_FIND, start, sel, 1'b0, 1'b0, '0);
            if (!last_found || last_value == VALUE_W'(VALUE_RANGE - 1)) break;
            start = last_value + 1'b1;
          end
        end else if (pick < 92) begin
          // lone find, any list code
          send_beat(bsid_pkg::REQ_FIND, VALUE_W'($urandom_range(VALUE_RANGE - 1)),
                    SEL_W'($urandom_range(3)), 1'b0, 1'b0, '0);
        end else begin
          // unused request code with random payload
          send_beat(REQ_UNUSED, VALUE_W'($urandom_range(VALUE_RANGE - 1)),
                    SEL_W'($urandom_range(3)), 1'b0, 1'b0, '0);
        end
      end
    end

    s_tvalid       <= 1'b0;
    sink_stall_pct = 0;
    while (pending_finds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d marks, %0d finds (%0d hits, %0d misses), %0d dropped beats",
             n_adds, n_finds, n_found, n_missed, n_ignored);
    $display("traffic ran with no gaps, source gaps, sink stalls, both, and a %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
